### rtl/bsfd_pkg.sv
// bsfd_pkg: shared types and constants of the byte-stuffed frame deframer
// no dependencies; imported by bsfd_cfg_regs, bsfd_parser, bsfd_out_stage, the core and bsfd_checker
`default_nettype none

package bsfd_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_XOR_MASK  = CFG_IDX_W'(2);

    localparam logic [7:0] DELIMITER_RST = 8'd126;
    localparam logic [7:0] ESCAPE_RST    = 8'd125;
    localparam logic [7:0] XOR_MASK_RST  = 8'd32;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_DROPPED  = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_BYTE   = 1'b0,
        CMD_RESYNC = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [7:0] delimiter_byte;
        logic [7:0] escape_byte;
        logic [7:0] xor_mask;
    } t_cfg;

    typedef struct packed {
        t_kind      event_kind;
        logic [7:0] payload_byte;
        logic [8:0] byte_index;
        logic [9:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

### rtl/bsfd_in_if.sv
// bsfd_in_if: input channel, one received byte or resync command per beat
// no dependencies
`default_nettype none

interface bsfd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/bsfd_out_if.sv
// bsfd_out_if: result channel, one deframer event per beat
// no dependencies
`default_nettype none

interface bsfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [8:0] byte_index;
    logic [9:0] frame_length;

    modport source (output valid, output event_kind, output payload_byte,
                    output byte_index, output frame_length, input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input byte_index, input frame_length, output ready);
endinterface

`default_nettype wire

### rtl/bsfd_cfg_regs.sv
// bsfd_cfg_regs: delimiter, escape and xor mask registers with write port
// depends on bsfd_pkg
`default_nettype none

module bsfd_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [bsfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [7:0]                        i_cfg_data,
    output bsfd_pkg::t_cfg                   o_cfg
);
    import bsfd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_byte <= DELIMITER_RST;
            r_cfg.escape_byte    <= ESCAPE_RST;
            r_cfg.xor_mask       <= XOR_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELIMITER: r_cfg.delimiter_byte <= i_cfg_data;
                REG_ESCAPE:    r_cfg.escape_byte    <= i_cfg_data;
                REG_XOR_MASK:  r_cfg.xor_mask       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/bsfd_parser.sv
// bsfd_parser: framing state and per-beat unstuffing step
// depends on bsfd_pkg
`default_nettype none

module bsfd_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 512
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  wire              i_command,
    input  wire [7:0]        i_rx_byte,
    input  bsfd_pkg::t_cfg   i_cfg,
    output logic             o_has_result,
    output bsfd_pkg::t_result o_result
);
    import bsfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    logic             r_inside;
    logic             r_esc;
    logic [CNT_W-1:0] r_count;
    logic             n_inside;
    logic             n_esc;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_inside     = r_inside;
        n_esc        = r_esc;
        n_count      = r_count;
        o_has_result = 1'b0;
        o_result     = '0;
        if (t_cmd'(i_command) == CMD_RESYNC) begin
            n_inside = 1'b0;
            n_esc    = 1'b0;
            n_count  = '0;
        end else if (i_rx_byte == i_cfg.delimiter_byte) begin
            if (r_inside && (r_count != '0)) begin
                n_inside              = 1'b0;
                o_has_result          = 1'b1;
                o_result.event_kind   = KIND_COMPLETE;
                o_result.frame_length = 10'(r_count);
            end else begin
                n_inside = 1'b1;
            end
            n_esc   = 1'b0;
            n_count = '0;
        end else if (!r_inside) begin
            n_inside = 1'b0;
        end else if (i_rx_byte == i_cfg.escape_byte) begin
            n_esc = 1'b1;
        end else if (r_count >= MAX_CNT) begin
            n_inside            = 1'b0;
            n_esc               = 1'b0;
            n_count             = '0;
            o_has_result        = 1'b1;
            o_result.event_kind = KIND_DROPPED;
        end else begin
            o_has_result          = 1'b1;
            o_result.event_kind   = KIND_PAYLOAD;
            o_result.payload_byte = r_esc ? (i_rx_byte ^ i_cfg.xor_mask) : i_rx_byte;
            o_result.byte_index   = 9'(r_count);
            n_esc                 = 1'b0;
            n_count               = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_esc    <= 1'b0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_inside <= n_inside;
            r_esc    <= n_esc;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/bsfd_out_stage.sv
// bsfd_out_stage: result register driving the event channel
// depends on bsfd_pkg and bsfd_out_if
`default_nettype none

module bsfd_out_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  bsfd_pkg::t_result  i_result,
    output logic               o_can_load,
    bsfd_out_if.source         o_ev
);
    import bsfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_ev.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_ev.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_ev.valid        = r_valid;
    assign o_ev.event_kind   = r_result.event_kind;
    assign o_ev.payload_byte = r_result.payload_byte;
    assign o_ev.byte_index   = r_result.byte_index;
    assign o_ev.frame_length = r_result.frame_length;

endmodule

`default_nettype wire

### rtl/byte_stuffed_frame_deframer_core.sv
// byte_stuffed_frame_deframer_core: top level of the byte-stuffed frame deframer
// depends on bsfd_pkg, bsfd_in_if, bsfd_out_if, bsfd_cfg_regs, bsfd_parser, bsfd_out_stage
// path: an accepted input beat is held in the input register, then its event, if any, in the result register
// throughput: one beat per cycle; input stalls only while the held beat has an event
// and the result register is full with the event sink not ready
// reset: synchronous active low, clears framing state, stages and config to defaults
`default_nettype none

module byte_stuffed_frame_deframer_core #(
    parameter int unsigned MAX_FRAME_BYTES = 512
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bsfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [7:0]                     i_cfg_data,
    bsfd_in_if.sink                       i_rx,
    bsfd_out_if.source                    o_ev
);
    import bsfd_pkg::*;

    t_cfg       cfg;
    t_result    result;
    logic       has_result;
    logic       can_load;
    logic       advance;
    logic       r_in_valid;
    logic       r_command;
    logic [7:0] r_rx_byte;

    assign advance    = r_in_valid && (!has_result || can_load);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_command <= i_rx.command;
            r_rx_byte <= i_rx.rx_byte;
        end
    end

    bsfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bsfd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_command    (r_command),
        .i_rx_byte    (r_rx_byte),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    bsfd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && has_result),
        .i_result   (result),
        .o_can_load (can_load),
        .o_ev       (o_ev)
    );

endmodule

`default_nettype wire

### rtl/bsfd_checker.sv
// bsfd_checker: port-level checks on the deframer event channel
// depends on bsfd_pkg; bound to byte_stuffed_frame_deframer_core
`default_nettype none

module bsfd_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire [1:0] i_event_kind,
    input wire [7:0] i_payload_byte,
    input wire [8:0] i_byte_index,
    input wire [9:0] i_frame_length
);
    import bsfd_pkg::*;

    // stalled beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_event_kind, i_payload_byte,
                                                     i_byte_index, i_frame_length}))
        else $error("event beat changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_event_kind != 2'd3)
        else $error("undefined event kind");

    // only payload events carry byte and index
    a_nonpayload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_event_kind != KIND_PAYLOAD |-> i_payload_byte == '0 && i_byte_index == '0)
        else $error("non-payload event carries payload fields");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_kind == KIND_PAYLOAD || i_event_kind == KIND_DROPPED)
            |-> i_frame_length == '0)
        else $error("frame length set on non-complete event");

endmodule

bind byte_stuffed_frame_deframer_core bsfd_checker u_bsfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_ev.valid),
    .i_ready        (o_ev.ready),
    .i_event_kind   (o_ev.event_kind),
    .i_payload_byte (o_ev.payload_byte),
    .i_byte_index   (o_ev.byte_index),
    .i_frame_length (o_ev.frame_length)
);

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for byte_stuffed_frame_deframer_core, random stuffed byte streams
// depends on rtl bsfd_pkg, bsfd_in_if, bsfd_out_if and the core; a local deframer predicts events
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfd_pkg::*;

    localparam int FRAME_MAX      = 512;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_rx_beat;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    bsfd_in_if  rx_if ();
    bsfd_out_if ev_if ();

    byte_stuffed_frame_deframer_core #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_ev       (ev_if)
    );

    // local copy of the deframer state and registers
    logic [7:0] cfg_delim;
    logic [7:0] cfg_esc;
    logic [7:0] cfg_mask;
    bit         in_frame;
    bit         esc_pending;
    int         frame_bytes;

    t_rx_beat    rx_backlog[$];
    t_result     pending_events[$];
    int          beats_queued;
    int          mismatches;
    int          quiet_cycles;
    logic        rx_took;
    int unsigned tx_gap;
    int unsigned ev_stall;
    bit          tx_calm;
    bit          ev_calm;
    bit          sink_hold_req;
    bit          sink_hold_done;
    int          sink_hold_cnt;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void deframe_beat(t_cmd cmd, logic [7:0] b);
        t_result r;
        r = '0;
        if (cmd == CMD_RESYNC) begin
            in_frame = 0;
            esc_pending = 0;
            frame_bytes = 0;
            return;
        end
        if (b == cfg_delim) begin
            if (in_frame && frame_bytes > 0) begin
                r.event_kind = KIND_COMPLETE;
                r.frame_length = 10'(frame_bytes);
                in_frame = 0;
                esc_pending = 0;
                frame_bytes = 0;
                pending_events.push_back(r);
                return;
            end
            in_frame = 1;
            esc_pending = 0;
            frame_bytes = 0;
            return;
        end
        if (!in_frame)
            return;
        if (b == cfg_esc) begin
            esc_pending = 1;
            return;
        end
        if (frame_bytes >= FRAME_MAX) begin
            in_frame = 0;
            esc_pending = 0;
            frame_bytes = 0;
            r.event_kind = KIND_DROPPED;
            pending_events.push_back(r);
            return;
        end
        r.event_kind = KIND_PAYLOAD;
        r.payload_byte = esc_pending ? (b ^ cfg_mask) : b;
        r.byte_index = 9'(frame_bytes);
        esc_pending = 0;
        frame_bytes++;
        pending_events.push_back(r);
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return cfg_delim;
        if (r < 40)
            return cfg_esc;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    // input driver
    always @(negedge clk) begin
        t_rx_beat nxt;
        if (!rst_n) begin
            rx_if.valid <= 1'b0;
            tx_gap <= 0;
        end else if (!rx_if.valid || rx_took) begin
            if ($urandom_range(0, 63) == 0)
                tx_calm <= !tx_calm;
            if (tx_gap != 0) begin
                rx_if.valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (rx_backlog.size() != 0) begin
                nxt = rx_backlog.pop_front();
                rx_if.valid <= 1'b1;
                rx_if.command <= nxt.cmd;
                rx_if.rx_byte <= nxt.data;
                tx_gap <= pick_gap(tx_calm);
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // event sink ready, with a long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            ev_if.ready <= 1'b0;
            ev_stall <= 0;
        end else if (sink_hold_req && !sink_hold_done) begin
            ev_if.ready <= 1'b0;
            if (sink_hold_cnt == HOLD_CYCLES)
                sink_hold_done <= 1'b1;
            else
                sink_hold_cnt <= sink_hold_cnt + 1;
        end else begin
            if (!sink_hold_req) begin
                sink_hold_done <= 1'b0;
                sink_hold_cnt <= 0;
            end
            if ($urandom_range(0, 63) == 0)
                ev_calm <= !ev_calm;
            if (ev_stall != 0) begin
                ev_if.ready <= 1'b0;
                ev_stall <= ev_stall - 1;
            end else begin
                ev_if.ready <= 1'b1;
                ev_stall <= pick_gap(ev_calm);
            end
        end
    end

    // monitor: predict on input beats, check event beats
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            rx_took <= 1'b0;
        end else begin
            rx_took <= rx_if.valid && rx_if.ready;
            if (rx_if.valid && rx_if.ready)
                deframe_beat(t_cmd'(rx_if.command), rx_if.rx_byte);
            if (ev_if.valid && ev_if.ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event beat, event_kind %0d", ev_if.event_kind);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (ev_if.event_kind !== want.event_kind) begin
                        $error("event_kind expected %0d got %0d",
                               want.event_kind, ev_if.event_kind);
                        mismatches++;
                    end
                    if (ev_if.payload_byte !== want.payload_byte) begin
                        $error("payload_byte expected %0h got %0h",
                               want.payload_byte, ev_if.payload_byte);
                        mismatches++;
                    end
                    if (ev_if.byte_index !== want.byte_index) begin
                        $error("byte_index expected %0d got %0d",
                               want.byte_index, ev_if.byte_index);
                        mismatches++;
                    end
                    if (ev_if.frame_length !== want.frame_length) begin
                        $error("frame_length expected %0d got %0d",
                               want.frame_length, ev_if.frame_length);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL byte_stuffed_frame_deframer_core");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b);
        rx_backlog.push_back('{cmd: CMD_BYTE, data: b});
        beats_queued++;
    endtask

    task automatic push_resync();
        rx_backlog.push_back('{cmd: CMD_RESYNC, data: 8'($urandom_range(0, 255))});
        beats_queued++;
    endtask

    // clean payload never sends a delimiter, only an occasional escape, so the frame stays open
    task automatic push_payload(bit clean);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (clean) begin
            while (v == cfg_delim || v == cfg_esc)
                v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                push_byte(cfg_esc);
            push_byte(v);
        end else if (v == cfg_delim || v == cfg_esc || $urandom_range(0, 9) == 0) begin
            push_byte(cfg_esc);
            push_byte(v ^ cfg_mask);
        end else begin
            push_byte(v);
        end
    endtask

    task automatic push_frame(int n_bytes, bit clean, bit close);
        push_byte(cfg_delim);
        repeat (n_bytes) push_payload(clean);
        if (close)
            push_byte(cfg_delim);
    endtask

    task automatic run_random(int n_beats);
        int stop_at;
        int unsigned r;
        stop_at = beats_queued + n_beats;
        while (beats_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                push_frame(frame_len(), 1'b0, 1'b1);
            end else if (r < 75) begin
                push_frame($urandom_range(0, 4), 1'b0, 1'b0);
                push_resync();
            end else if (r < 88) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 4) == 0)
                        push_resync();
                    else
                        push_byte(pick_byte());
                end
            end else if (r < 94) begin
                push_byte(cfg_delim);
                push_payload(1'b0);
                push_byte(cfg_esc);
                push_byte(cfg_esc);
                push_byte(pick_byte());
                push_byte(cfg_delim);
            end else begin
                push_byte(cfg_delim);
                push_byte(cfg_delim);
                push_byte(cfg_esc);
                push_byte(cfg_delim);
            end
        end
    endtask

    task automatic settle();
        while (rx_backlog.size() != 0 || rx_if.valid || pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELIMITER: cfg_delim = val;
            REG_ESCAPE:    cfg_esc = val;
            REG_XOR_MASK:  cfg_mask = val;
            default: ;
        endcase
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DELIMITER;
        cfg_data = 8'h00;
        rx_if.valid = 1'b0;
        rx_if.command = CMD_BYTE;
        rx_if.rx_byte = 8'h00;
        ev_if.ready = 1'b0;
        rx_took = 1'b0;
        cfg_delim = DELIMITER_RST;
        cfg_esc = ESCAPE_RST;
        cfg_mask = XOR_MASK_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, hand-picked stream
        push_resync();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESCAPE_RST);
        push_byte(DELIMITER_RST);
        push_byte(DELIMITER_RST);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESCAPE_RST);
        push_byte(ESCAPE_RST);
        push_byte(DELIMITER_RST ^ XOR_MASK_RST);
        push_byte(ESCAPE_RST);
        push_byte(DELIMITER_RST);
        push_byte(DELIMITER_RST);
        push_byte(ESCAPE_RST);
        push_byte(ESCAPE_RST ^ XOR_MASK_RST);
        push_byte(8'hA5);
        push_resync();
        push_byte(8'h11);
        push_byte(DELIMITER_RST);
        push_byte(8'h55);
        push_byte(DELIMITER_RST);
        settle();

        run_random(20);
        // sink holds off while the backlog keeps coming
        run_random(40);
        @(posedge clk);
        sink_hold_req = 1'b1;
        wait (sink_hold_done);
        @(posedge clk);
        sink_hold_req = 1'b0;
        run_random(40);
        settle();

        write_reg(REG_DELIMITER, 8'h00);
        write_reg(REG_ESCAPE, 8'hFF);
        write_reg(REG_XOR_MASK, 8'hFF);
        run_random(40);
        settle();
        run_random(30);
        settle();

        // escape byte equal to delimiter
        write_reg(REG_DELIMITER, 8'h55);
        write_reg(REG_ESCAPE, 8'h55);
        write_reg(REG_XOR_MASK, 8'h00);
        push_resync();
        push_byte(8'h55);
        push_byte(8'h12);
        push_byte(8'h55);
        run_random(30);
        settle();

        // full-size frame, escape at full, then one byte too many
        write_reg(REG_DELIMITER, 8'hFF);
        write_reg(REG_ESCAPE, 8'h00);
        write_reg(REG_XOR_MASK, 8'hAA);
        push_frame(FRAME_MAX, 1'b1, 1'b0);
        push_byte(cfg_esc);
        push_payload(1'b1);
        push_byte(8'h37);
        push_byte(cfg_esc);
        push_frame(3, 1'b1, 1'b1);
        run_random(30);
        settle();

        if (mismatches == 0)
            $display("PASS byte_stuffed_frame_deframer_core");
        else
            $display("FAIL byte_stuffed_frame_deframer_core");
        $finish;
    end
endmodule
